@@ rtl/core/khrb_pkg.sv @@
`default_nettype none
package khrb_pkg;

  localparam int unsigned KEY_SLOTS = 5;
  localparam int unsigned RPT_SLOTS = 5;
  localparam int unsigned CNT_W = $clog2(KEY_SLOTS + 1);
  localparam int unsigned IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ID_KEYBOARD = 2'd1;
  localparam logic [1:0] ID_MEDIA = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_KEY,
    OP_MOD,
    OP_MEDIA
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/khrb_front.sv @@
`default_nettype none
module khrb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          pressed_i,
  input  wire logic [7:0]    key_code_i,
  input  wire logic [7:0]    modifier_bits_i,
  input  wire logic [7:0]    layer_key_code_i,
  input  wire logic [7:0]    layer_media_bits_i,
  input  wire logic          is_layer_key_i,
  input  wire logic          last_of_scan_i,
  output khrb_pkg::cmd_t     cmd_o
);

  logic layer_q, layer_d;

  always_comb begin
    cmd_o.op   = khrb_pkg::OP_NONE;
    cmd_o.data = 8'd0;
    cmd_o.last = last_of_scan_i;
    layer_d    = layer_q;
    if (pressed_i) begin
      if (!layer_q) begin
        if (key_code_i != 8'd0) begin
          cmd_o.op   = khrb_pkg::OP_KEY;
          cmd_o.data = key_code_i;
        end else if (modifier_bits_i != 8'd0) begin
          cmd_o.op   = khrb_pkg::OP_MOD;
          cmd_o.data = modifier_bits_i;
        end else if (is_layer_key_i) begin
          layer_d = 1'b1;
        end
      end else begin
        if (layer_key_code_i != 8'd0) begin
          cmd_o.op   = khrb_pkg::OP_KEY;
          cmd_o.data = layer_key_code_i;
        end else if (layer_media_bits_i != 8'd0) begin
          cmd_o.op   = khrb_pkg::OP_MEDIA;
          cmd_o.data = layer_media_bits_i;
        end
      end
    end
    if (last_of_scan_i) begin
      layer_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= 1'b0;
    end else if (accept_i) begin
      layer_q <= layer_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/khrb_cmd_queue.sv @@
`default_nettype none
module khrb_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire khrb_pkg::cmd_t wr_cmd_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output khrb_pkg::cmd_t     rd_cmd_o,
  output logic               valid_o
);

  localparam int unsigned PtrW = $clog2(khrb_pkg::QUEUE_DEPTH);

  khrb_pkg::cmd_t entry_q [khrb_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o   = (count_q == (PtrW + 1)'(khrb_pkg::QUEUE_DEPTH));
  assign valid_o  = (count_q != '0);
  assign rd_cmd_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/khrb_back.sv @@
`default_nettype none
module khrb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire khrb_pkg::cmd_t cmd_i,
  output logic               cmd_take_o,
  input  wire logic          pop,
  output logic               empty,
  output logic [1:0]         report_id_o,
  output logic [7:0]         modifiers_o,
  output logic [7:0]         slot0_o,
  output logic [7:0]         slot1_o,
  output logic [7:0]         slot2_o,
  output logic [7:0]         slot3_o,
  output logic [7:0]         slot4_o,
  output logic [7:0]         media_o
);

  logic [7:0] slot_q [khrb_pkg::KEY_SLOTS];
  logic [7:0] slot_d [khrb_pkg::KEY_SLOTS];
  logic [khrb_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0] mod_q, mod_d, media_q, media_d;
  logic mod_seen_q, mod_seen_d, media_seen_q, media_seen_d;
  logic kb_rep_q, kb_rep_d, md_rep_q, md_rep_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] id_q, id_d;
  logic [7:0] omod_q, omod_d, omedia_q, omedia_d;
  logic [7:0] oslot_q [khrb_pkg::RPT_SLOTS];
  logic [7:0] oslot_d [khrb_pkg::RPT_SLOTS];

  logic out_free;
  logic [khrb_pkg::IDX_W-1:0] wr_idx;

  assign out_free   = !out_valid_q || pop;
  assign cmd_take_o = cmd_valid_i && (!cmd_i.last || out_free);
  assign empty      = !out_valid_q;

  assign report_id_o = id_q;
  assign modifiers_o = omod_q;
  assign slot0_o     = oslot_q[0];
  assign slot1_o     = oslot_q[1];
  assign slot2_o     = oslot_q[2];
  assign slot3_o     = oslot_q[3];
  assign slot4_o     = oslot_q[4];
  assign media_o     = omedia_q;

  always_comb begin
    if (count_q >= khrb_pkg::CNT_W'(khrb_pkg::KEY_SLOTS)) begin
      wr_idx = khrb_pkg::IDX_W'(khrb_pkg::KEY_SLOTS - 1);
    end else begin
      wr_idx = count_q[khrb_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    slot_d       = slot_q;
    count_d      = count_q;
    mod_d        = mod_q;
    media_d      = media_q;
    mod_seen_d   = mod_seen_q;
    media_seen_d = media_seen_q;
    kb_rep_d     = kb_rep_q;
    md_rep_d     = md_rep_q;
    out_valid_d  = out_valid_q && !pop;
    id_d         = id_q;
    omod_d       = omod_q;
    omedia_d     = omedia_q;
    oslot_d      = oslot_q;

    case (cmd_i.op)
      khrb_pkg::OP_KEY: begin
        slot_d[wr_idx] = cmd_i.data;
        if (count_q < khrb_pkg::CNT_W'(khrb_pkg::KEY_SLOTS)) begin
          count_d = count_q + 1'b1;
        end
      end
      khrb_pkg::OP_MOD: begin
        mod_d      = mod_q | cmd_i.data;
        mod_seen_d = 1'b1;
      end
      khrb_pkg::OP_MEDIA: begin
        media_d      = media_q | cmd_i.data;
        media_seen_d = 1'b1;
      end
      default: begin
      end
    endcase

    if (cmd_i.last) begin
      omod_d   = 8'd0;
      omedia_d = 8'd0;
      for (int k = 0; k < khrb_pkg::RPT_SLOTS; k++) begin
        oslot_d[k] = 8'd0;
      end
      if (count_d != '0 || mod_seen_d) begin
        out_valid_d = 1'b1;
        id_d        = khrb_pkg::ID_KEYBOARD;
        omod_d      = mod_d;
        for (int k = 0; k < khrb_pkg::RPT_SLOTS && k < khrb_pkg::KEY_SLOTS; k++) begin
          oslot_d[k] = slot_d[k];
        end
        kb_rep_d = 1'b1;
      end else if (media_seen_d) begin
        out_valid_d = 1'b1;
        id_d        = khrb_pkg::ID_MEDIA;
        omedia_d    = media_d;
        md_rep_d    = 1'b1;
      end else if (kb_rep_q) begin
        out_valid_d = 1'b1;
        id_d        = khrb_pkg::ID_KEYBOARD;
        kb_rep_d    = 1'b0;
      end else if (md_rep_q) begin
        out_valid_d = 1'b1;
        id_d        = khrb_pkg::ID_MEDIA;
        md_rep_d    = 1'b0;
      end
      for (int i = 0; i < khrb_pkg::KEY_SLOTS; i++) begin
        slot_d[i] = 8'd0;
      end
      count_d      = '0;
      mod_d        = 8'd0;
      media_d      = 8'd0;
      mod_seen_d   = 1'b0;
      media_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < khrb_pkg::KEY_SLOTS; i++) begin
        slot_q[i] <= 8'd0;
      end
      count_q      <= '0;
      mod_q        <= 8'd0;
      media_q      <= 8'd0;
      mod_seen_q   <= 1'b0;
      media_seen_q <= 1'b0;
      kb_rep_q     <= 1'b0;
      md_rep_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (cmd_take_o) begin
      slot_q       <= slot_d;
      count_q      <= count_d;
      mod_q        <= mod_d;
      media_q      <= media_d;
      mod_seen_q   <= mod_seen_d;
      media_seen_q <= media_seen_d;
      kb_rep_q     <= kb_rep_d;
      md_rep_q     <= md_rep_d;
      out_valid_q  <= out_valid_d;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_i.last) begin
      id_q     <= id_d;
      omod_q   <= omod_d;
      omedia_q <= omedia_d;
      oslot_q  <= oslot_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/key_matrix_hid_report_builder_core.sv @@
// Builds USB HID keyboard and media reports from a stream of scanned key samples, one
// word per matrix position. A word is accepted in every cycle in which push is high and
// full is low; the front stage classifies it and tracks the Fn layer, a two-entry queue
// decouples it from the back stage, which accumulates slots, modifiers and media bits and
// forms at most one report per scan. The last word of a scan passes through the queue and
// is taken by the back stage once the output register is free; the report is then held in
// a single output register until popped; a new report is formed in the cycle that register
// is popped; words flow at one per cycle unless full is high or a report waits unpopped.
`default_nettype none
module key_matrix_hid_report_builder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       pressed_i,
  input  wire logic [7:0] key_code_i,
  input  wire logic [7:0] modifier_bits_i,
  input  wire logic [7:0] layer_key_code_i,
  input  wire logic [7:0] layer_media_bits_i,
  input  wire logic       is_layer_key_i,
  input  wire logic       last_of_scan_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      report_id_o,
  output logic [7:0]      modifiers_o,
  output logic [7:0]      slot0_o,
  output logic [7:0]      slot1_o,
  output logic [7:0]      slot2_o,
  output logic [7:0]      slot3_o,
  output logic [7:0]      slot4_o,
  output logic [7:0]      media_o
);

  logic           accept;
  logic           cmd_valid;
  logic           cmd_take;
  khrb_pkg::cmd_t front_cmd;
  khrb_pkg::cmd_t queue_cmd;

  assign accept = push && !full;

  khrb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .pressed_i          (pressed_i),
    .key_code_i         (key_code_i),
    .modifier_bits_i    (modifier_bits_i),
    .layer_key_code_i   (layer_key_code_i),
    .layer_media_bits_i (layer_media_bits_i),
    .is_layer_key_i     (is_layer_key_i),
    .last_of_scan_i     (last_of_scan_i),
    .cmd_o              (front_cmd)
  );

  khrb_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept),
    .wr_cmd_i (front_cmd),
    .full_o   (full),
    .rd_en_i  (cmd_take),
    .rd_cmd_o (queue_cmd),
    .valid_o  (cmd_valid)
  );

  khrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (queue_cmd),
    .cmd_take_o  (cmd_take),
    .pop         (pop),
    .empty       (empty),
    .report_id_o (report_id_o),
    .modifiers_o (modifiers_o),
    .slot0_o     (slot0_o),
    .slot1_o     (slot1_o),
    .slot2_o     (slot2_o),
    .slot3_o     (slot3_o),
    .slot4_o     (slot4_o),
    .media_o     (media_o)
  );

endmodule
`default_nettype wire
